FILE: rtl/wem_pkg.sv
`default_nettype none

package wem_pkg;

   localparam int GRID_SIZE_DEFAULT = 16;

   // counter range and the steps applied to it
   localparam int EV_LIMIT = 3;
   localparam int EV_BUMP  = 2;
   localparam int EV_SURE  = 2;

   localparam int EV_WIDTH    = 3;
   localparam int COUNT_WIDTH = 9;

   localparam logic [2:0] ACT_OBSERVE = 3'd0;
   localparam logic [2:0] ACT_CROSSED = 3'd1;
   localparam logic [2:0] ACT_BLOCKED = 3'd2;
   localparam logic [2:0] ACT_QUERY   = 3'd3;
   localparam logic [2:0] ACT_FORGET  = 3'd4;

   localparam logic [1:0] SIDE_NORTH = 2'd0;
   localparam logic [1:0] SIDE_EAST  = 2'd1;
   localparam logic [1:0] SIDE_SOUTH = 2'd2;
   localparam logic [1:0] SIDE_WEST  = 2'd3;

   localparam logic [1:0] WS_UNKNOWN = 2'd0;
   localparam logic [1:0] WS_PRESENT = 2'd1;
   localparam logic [1:0] WS_ABSENT  = 2'd2;

   typedef logic signed [EV_WIDTH-1:0] ev_type;

   function automatic logic [1:0] wall_state_of(input ev_type ev);
      logic [1:0] ws;
      if (ev > 0) begin
         ws = WS_PRESENT;
      end else if (ev < 0) begin
         ws = WS_ABSENT;
      end else begin
         ws = WS_UNKNOWN;
      end
      return ws;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/wall_evidence_map.sv
`default_nettype none

// Wall evidence store for a GRID_SIZE x GRID_SIZE cell grid.
// A request is transferred at a rising edge with start high and busy low. It
// names a cell, a side and an action (observe, crossed, blocked, query or
// forget). The block holds one saturating counter from -3 to +3 per interior
// wall in two memories (north walls and east walls), one entry per cell.
// Observe, crossed and blocked requests do one read-modify-write of the memory
// and query requests one read: busy through the read and update states after
// the transfer, and rsp_valid pulses once the block is back in idle; a new
// request can be transferred in that same cycle, but not before that pulse.
// Forget sweeps both memories together, one entry per cycle through the single
// read and write port of each.
// Border sides and cells outside the grid read as a fixed wall (evidence 3)
// and are never written.
// Each response is on the rsp_ ports for exactly one cycle, marked by
// rsp_valid; the receiver cannot stall it.
// After reset a clearing pass zeroes every entry, during which busy is high
// and no request is taken.
module wall_evidence_map
   import wem_pkg::*;
#(
   parameter int GRID_SIZE = GRID_SIZE_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic [2:0]             req_action,
   input  wire logic [3:0]             req_cell_x,
   input  wire logic [3:0]             req_cell_y,
   input  wire logic [1:0]             req_side,
   input  wire logic                   req_present,
   input  wire logic signed [2:0]      req_forget_limit,
   output logic                        rsp_valid,
   output logic signed [2:0]           rsp_evidence,
   output logic [1:0]                  rsp_wall_state,
   output logic                        rsp_on_border,
   output logic                        rsp_open_explore,
   output logic                        rsp_open_verified,
   output logic [COUNT_WIDTH-1:0]      rsp_forgot_count
);

   localparam int CELLS = GRID_SIZE * GRID_SIZE;
   localparam int AW = $clog2(CELLS);
   localparam logic [AW-1:0] LAST_ADDR = AW'(CELLS - 1);
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_CLEAR  = 6'b000010,
      ST_READ   = 6'b000100,
      ST_UPDATE = 6'b001000,
      ST_FORGET = 6'b010000,
      ST_FDRAIN = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic [AW-1:0] sweep_ff, sweep_in;
   logic pend_ff, pend_in;
   logic [AW-1:0] pend_addr_ff, pend_addr_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;

   logic [2:0] act_ff, act_in;
   logic [3:0] x_ff, x_in;
   logic [3:0] y_ff, y_in;
   logic [1:0] side_ff, side_in;
   logic present_ff, present_in;
   ev_type limit_ff, limit_in;

   logic rsp_valid_ff, rsp_valid_in;
   ev_type rsp_ev_ff, rsp_ev_in;
   logic [1:0] rsp_ws_ff, rsp_ws_in;
   logic rsp_border_ff, rsp_border_in;
   logic rsp_explore_ff, rsp_explore_in;
   logic rsp_verified_ff, rsp_verified_in;
   logic [COUNT_WIDTH-1:0] rsp_count_ff, rsp_count_in;

   // memories, one read port and one write port each
   logic [EV_WIDTH-1:0] north_mem [CELLS];
   logic [EV_WIDTH-1:0] east_mem [CELLS];
   ev_type rd_north_ff, rd_east_ff;
   logic [AW-1:0] rd_addr, wr_addr;
   logic wr_en_north, wr_en_east;
   ev_type wr_data;

   logic [AW-1:0] addr_calc;
   logic border_calc;
   logic is_north;
   ev_type ev_old, ev_new;
   logic qual_north, qual_east;
   logic [COUNT_WIDTH:0] count_sum;

   // wall address and border check from the held request
   always_comb begin
      int ax;
      int ay;
      logic outside;
      ax = int'(x_ff);
      ay = int'(y_ff);
      outside = (int'(x_ff) >= GRID_SIZE) || (int'(y_ff) >= GRID_SIZE);
      border_calc = outside;
      case (side_ff)
         SIDE_NORTH: begin
            border_calc = outside || (int'(y_ff) + 1 >= GRID_SIZE);
         end
         SIDE_EAST: begin
            border_calc = outside || (int'(x_ff) + 1 >= GRID_SIZE);
         end
         SIDE_SOUTH: begin
            border_calc = outside || (y_ff == 4'd0);
            ay = int'(y_ff) - 1;
         end
         SIDE_WEST: begin
            border_calc = outside || (x_ff == 4'd0);
            ax = int'(x_ff) - 1;
         end
         default: begin
            border_calc = 1'b1;
         end
      endcase
      addr_calc = AW'(ax * GRID_SIZE + ay);
   end

   assign is_north = (side_ff == SIDE_NORTH) || (side_ff == SIDE_SOUTH);
   assign ev_old = is_north ? rd_north_ff : rd_east_ff;

   always_comb begin
      ev_new = ev_old;
      case (act_ff)
         ACT_OBSERVE: begin
            if (present_ff) begin
               if (ev_old < ev_type'(EV_LIMIT)) begin
                  ev_new = ev_old + ev_type'(1);
               end
            end else if (ev_old > -ev_type'(EV_LIMIT)) begin
               ev_new = ev_old - ev_type'(1);
            end
         end
         ACT_CROSSED: begin
            ev_new = -ev_type'(EV_LIMIT);
         end
         ACT_BLOCKED: begin
            // any positive count plus the bump saturates at the limit
            ev_new = (ev_old > 0) ? ev_type'(EV_LIMIT) : ev_type'(EV_BUMP);
         end
         default: begin
            ev_new = ev_old;
         end
      endcase
   end

   assign qual_north = (rd_north_ff > 0) && (rd_north_ff <= limit_ff);
   assign qual_east = (rd_east_ff > 0) && (rd_east_ff <= limit_ff);
   assign count_sum = {1'b0, count_ff} + (COUNT_WIDTH + 1)'(qual_north)
                      + (COUNT_WIDTH + 1)'(qual_east);

   always_comb begin
      state_in = state_ff;
      sweep_in = sweep_ff;
      pend_in = pend_ff;
      pend_addr_in = pend_addr_ff;
      count_in = count_ff;
      act_in = act_ff;
      x_in = x_ff;
      y_in = y_ff;
      side_in = side_ff;
      present_in = present_ff;
      limit_in = limit_ff;
      rsp_valid_in = 1'b0;
      rsp_ev_in = rsp_ev_ff;
      rsp_ws_in = rsp_ws_ff;
      rsp_border_in = rsp_border_ff;
      rsp_explore_in = rsp_explore_ff;
      rsp_verified_in = rsp_verified_ff;
      rsp_count_in = rsp_count_ff;
      rd_addr = sweep_ff;
      wr_addr = sweep_ff;
      wr_en_north = 1'b0;
      wr_en_east = 1'b0;
      wr_data = '0;

      // write back a swept entry whose read data has arrived
      if (pend_ff) begin
         wr_addr = pend_addr_ff;
         wr_en_north = qual_north;
         wr_en_east = qual_east;
         count_in = count_sum[COUNT_WIDTH] ? COUNT_MAX : count_sum[COUNT_WIDTH-1:0];
      end

      case (state_ff)
         ST_CLEAR: begin
            wr_en_north = 1'b1;
            wr_en_east = 1'b1;
            sweep_in = sweep_ff + AW'(1);
            if (sweep_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               act_in = req_action;
               x_in = req_cell_x;
               y_in = req_cell_y;
               side_in = req_side;
               present_in = req_present;
               limit_in = req_forget_limit;
               if (req_action == ACT_FORGET) begin
                  sweep_in = '0;
                  count_in = '0;
                  pend_in = 1'b0;
                  state_in = ST_FORGET;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            rd_addr = addr_calc;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            wr_addr = addr_calc;
            wr_data = ev_new;
            if (!border_calc && (act_ff == ACT_OBSERVE || act_ff == ACT_CROSSED
                                 || act_ff == ACT_BLOCKED)) begin
               wr_en_north = is_north;
               wr_en_east = !is_north;
            end
            rsp_valid_in = 1'b1;
            rsp_count_in = '0;
            rsp_border_in = border_calc;
            if (border_calc) begin
               rsp_ev_in = ev_type'(EV_LIMIT);
               rsp_ws_in = WS_PRESENT;
               rsp_explore_in = 1'b0;
               rsp_verified_in = 1'b0;
            end else begin
               rsp_ev_in = ev_new;
               rsp_ws_in = wall_state_of(ev_new);
               rsp_explore_in = (ev_new <= 0);
               rsp_verified_in = (ev_new <= -ev_type'(EV_SURE));
            end
            state_in = ST_IDLE;
         end
         ST_FORGET: begin
            rd_addr = sweep_ff;
            pend_in = 1'b1;
            pend_addr_in = sweep_ff;
            sweep_in = sweep_ff + AW'(1);
            if (sweep_ff == LAST_ADDR) begin
               state_in = ST_FDRAIN;
            end
         end
         ST_FDRAIN: begin
            pend_in = 1'b0;
            rsp_valid_in = 1'b1;
            rsp_ev_in = '0;
            rsp_ws_in = WS_UNKNOWN;
            rsp_border_in = 1'b0;
            rsp_explore_in = 1'b0;
            rsp_verified_in = 1'b0;
            rsp_count_in = count_in;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         sweep_ff <= '0;
         pend_ff <= 1'b0;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sweep_ff <= sweep_in;
         pend_ff <= pend_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_addr_ff <= pend_addr_in;
      act_ff <= act_in;
      x_ff <= x_in;
      y_ff <= y_in;
      side_ff <= side_in;
      present_ff <= present_in;
      limit_ff <= limit_in;
      rsp_ev_ff <= rsp_ev_in;
      rsp_ws_ff <= rsp_ws_in;
      rsp_border_ff <= rsp_border_in;
      rsp_explore_ff <= rsp_explore_in;
      rsp_verified_ff <= rsp_verified_in;
      rsp_count_ff <= rsp_count_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en_north) begin
         north_mem[wr_addr] <= wr_data;
      end
      if (wr_en_east) begin
         east_mem[wr_addr] <= wr_data;
      end
      rd_north_ff <= north_mem[rd_addr];
      rd_east_ff <= east_mem[rd_addr];
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_evidence = rsp_ev_ff;
   assign rsp_wall_state = rsp_ws_ff;
   assign rsp_on_border = rsp_border_ff;
   assign rsp_open_explore = rsp_explore_ff;
   assign rsp_open_verified = rsp_verified_ff;
   assign rsp_forgot_count = rsp_count_ff;

`ifndef ASSERT_OFF
   a_rsp_from_update: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_UPDATE || state_ff == ST_FDRAIN))
      else $error("response strobe without a finishing step");

   a_transfer_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request transfer did not start work");

   a_border_is_wall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_on_border) |-> (rsp_evidence == ev_type'(EV_LIMIT)
                                        && !rsp_open_explore))
      else $error("border response not a fixed wall");

   a_verified_is_open: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_open_verified) |-> rsp_open_explore)
      else $error("verified opening not reported open");

   a_forget_only_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_forgot_count != '0) |-> (rsp_evidence == '0
                                                 && !rsp_on_border))
      else $error("forget response carries wall fields");
`endif

endmodule

`default_nettype wire
